// ===== rtl/lbdu_pkg.sv =====
// package for the lattice birth/death update block
// widths, sizes, event codes and configuration indexes; no dependencies
`default_nettype none
package lbdu_pkg;
  localparam int MaxRows   = 64;
  localparam int MaxCols   = 64;
  localparam int RowW      = $clog2(MaxRows);
  localparam int ColW      = $clog2(MaxCols);
  localparam int SiteW     = RowW + ColW;
  localparam int SiteCap   = MaxRows * MaxCols;
  localparam int CountW    = SiteW + 1;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0, EV_ANNIH = 3'd1, EV_CREATE = 3'd2,
    EV_COAG = 3'd3, EV_SEED = 3'd4, EV_INVALID = 3'd5
  } event_t;

  localparam logic [1:0] CFG_ROWS   = 2'd0;
  localparam logic [1:0] CFG_COLS   = 2'd1;
  localparam logic [1:0] CFG_ATHR   = 2'd2;
  localparam logic [1:0] CFG_CTHR   = 2'd3;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/lbdu_ram.sv =====
// generic single-port-write, single-read RAM with registered read data
// no dependencies
`default_nettype none
module lbdu_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/lattice_birth_death_update_top.sv =====
// top level of the lattice birth/death update block
// uses lbdu_pkg and three lbdu_ram instances (occupancy, list, slot map)
//
// channel   direction  handshake            payload
// in_       in         start / busy         operation, list_index, rand_frac, direction, seed
// out_      out        out_valid strobe     event_res, changed_row/col, occupied_count
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// busy stays high from the accepting edge until the result strobe, over the chain of dependent
// memory accesses that the item needs (list read, occupancy read, slot map read, last entry
// read, then write-back): an invalid item needs none, a seed the occupancy read and write, a
// creation or blocked event the list and occupancy reads, an annihilation the list and last
// entry reads and the write-back, a coagulation all; the result strobe comes as busy falls
// after reset the occupancy memory is cleared, one site a cycle, all 4096 sites; busy
// stays high meanwhile; cfg_ready is low while an item is in flight or being started;
// results are shown for one cycle and cannot be stalled
`default_nettype none
module lattice_birth_death_update_top
  import lbdu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_operation,
  input  wire logic [12:0] in_list_index,
  input  wire logic [15:0] in_rand_frac,
  input  wire logic [1:0]  in_direction,
  input  wire logic [6:0]  in_seed_row,
  input  wire logic [6:0]  in_seed_col,
  output logic             out_valid,
  output logic [2:0]       out_event_res,
  output logic [6:0]       out_changed_row,
  output logic [6:0]       out_changed_col,
  output logic [12:0]      out_occupied_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SEED_RD, S_SEED_CHK, S_LIST_RD, S_SITE, S_NB_CHK,
    S_MAP_WAIT, S_LAST_WAIT, S_DROP, S_DONE
  } state_t;

  state_t state_r;
  logic [6:0]  rows_r, cols_r;
  logic [16:0] athr_r, cthr_r;
  logic [CountW-1:0] count_r;
  logic [SiteW-1:0] clr_r;
  logic [15:0] frac_r;
  logic [1:0]  dir_r;
  logic [6:0]  srow_r, scol_r;
  logic [SiteW-1:0] site_r;     // site being changed
  logic [SiteW-1:0] slot_r;     // slot being freed
  logic [2:0]  ev_r;
  logic [6:0]  orow_r, ocol_r;

  // memory ports
  logic             occ_we, occ_wd, occ_rd;
  logic [SiteW-1:0] occ_wa, occ_ra;
  logic             lst_we;
  logic [SiteW-1:0] lst_wa, lst_wd, lst_ra, lst_rd;
  logic             map_we;
  logic [SiteW-1:0] map_wa, map_wd, map_ra, map_rd;

  lbdu_ram #(.Width(1), .Depth(SiteCap)) u_occ (
    .clk(clk), .we(occ_we), .waddr(occ_wa), .wdata(occ_wd), .raddr(occ_ra), .rdata(occ_rd));
  lbdu_ram #(.Width(SiteW), .Depth(SiteCap)) u_list (
    .clk(clk), .we(lst_we), .waddr(lst_wa), .wdata(lst_wd), .raddr(lst_ra), .rdata(lst_rd));
  lbdu_ram #(.Width(SiteW), .Depth(SiteCap)) u_map (
    .clk(clk), .we(map_we), .waddr(map_wa), .wdata(map_wd), .raddr(map_ra), .rdata(map_rd));

  // clamped dimensions
  logic [6:0] nr, nc;
  always_comb begin
    nr = (rows_r < 7'd2) ? 7'd2 : ((rows_r > 7'(MaxRows)) ? 7'(MaxRows) : rows_r);
    nc = (cols_r < 7'd2) ? 7'd2 : ((cols_r > 7'(MaxCols)) ? 7'(MaxCols) : cols_r);
  end

  // decode of the listed site and its neighbour
  logic [6:0] cr, cc, tr, tc;
  logic [SiteW-1:0] nsite;
  always_comb begin
    cr = 7'(lst_rd[SiteW-1:ColW]) + 7'd1;
    cc = 7'(lst_rd[ColW-1:0]) + 7'd1;
    tr = cr;
    tc = cc;
    case (dir_r)
      DIR_UP:   tr = (cr <= 7'd1) ? nr : cr - 7'd1;
      DIR_DOWN: tr = (cr >= nr) ? 7'd1 : cr + 7'd1;
      DIR_LEFT: tc = (cc <= 7'd1) ? nc : cc - 7'd1;
      default:  tc = (cc >= nc) ? 7'd1 : cc + 7'd1;
    endcase
    nsite = {RowW'(tr - 7'd1), ColW'(tc - 7'd1)};
  end

  logic [SiteW-1:0] seed_site, last_slot;
  logic seed_bad, idx_bad, full;
  always_comb begin
    seed_site = {RowW'(in_seed_row - 7'd1), ColW'(in_seed_col - 7'd1)};
    seed_bad  = (in_seed_row == 7'd0) || (in_seed_row > nr) ||
                (in_seed_col == 7'd0) || (in_seed_col > nc);
    idx_bad   = (in_list_index == 13'd0) || (in_list_index > 13'(count_r));
    full      = (count_r >= CountW'(SiteCap));
    last_slot = SiteW'(count_r - CountW'(1));
  end

  // memory port steering
  always_comb begin
    occ_we = 1'b0; occ_wa = site_r; occ_wd = 1'b0; occ_ra = seed_site;
    lst_we = 1'b0; lst_wa = SiteW'(count_r); lst_wd = site_r;
    lst_ra = SiteW'(in_list_index - 13'd1);
    map_we = 1'b0; map_wa = site_r; map_wd = SiteW'(count_r); map_ra = nsite;
    case (state_r)
      S_CLEAR: begin
        occ_we = 1'b1; occ_wa = clr_r;
      end
      S_LIST_RD: lst_ra = slot_r;
      S_SITE: begin
        occ_ra = nsite;
        lst_ra = last_slot;
        if (frac_r < athr_r) begin
          occ_we = 1'b1; occ_wa = lst_rd;
        end
      end
      S_MAP_WAIT, S_LAST_WAIT: lst_ra = last_slot;
      S_SEED_CHK: begin
        if (ev_r == EV_SEED) begin
          occ_we = 1'b1; occ_wd = 1'b1;
          lst_we = 1'b1; map_we = 1'b1;
        end
      end
      S_NB_CHK: begin
        map_ra = site_r;
        if (ev_r == EV_CREATE && !occ_rd && !full) begin
          occ_we = 1'b1; occ_wd = 1'b1;
          lst_we = 1'b1; map_we = 1'b1;
        end else if (ev_r == EV_COAG) begin
          occ_we = 1'b1;
        end
      end
      S_DROP: begin
        lst_we = 1'b1; lst_wa = slot_r; lst_wd = lst_rd;
        map_we = 1'b1; map_wa = lst_rd; map_wd = slot_r;
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;

  // control, configuration and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; count_r <= '0;
      rows_r <= 7'd64; cols_r <= 7'd64; athr_r <= 17'd21845; cthr_r <= 17'd43690;
      out_valid <= 1'b0; ev_r <= EV_NONE;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROWS: rows_r <= cfg_data[6:0];
          CFG_COLS: cols_r <= cfg_data[6:0];
          CFG_ATHR: athr_r <= cfg_data;
          CFG_CTHR: cthr_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + SiteW'(1);
          if (clr_r == SiteW'(SiteCap - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          frac_r <= in_rand_frac;
          dir_r <= in_direction; srow_r <= in_seed_row; scol_r <= in_seed_col;
          site_r <= seed_site; slot_r <= SiteW'(in_list_index - 13'd1);
          orow_r <= 7'd0; ocol_r <= 7'd0;
          if (!in_operation) begin
            if (seed_bad) begin ev_r <= EV_INVALID; state_r <= S_DONE; end
            else state_r <= S_SEED_RD;
          end else if (idx_bad) begin
            ev_r <= EV_INVALID; state_r <= S_DONE;
          end else state_r <= S_LIST_RD;
        end
        S_SEED_RD: begin
          // occupancy data of the seed site, read at the accepting edge, is already valid here
          if (!occ_rd && !full) begin
            ev_r <= EV_SEED; orow_r <= srow_r; ocol_r <= scol_r;
          end else ev_r <= EV_NONE;
          state_r <= S_SEED_CHK;
        end
        S_SEED_CHK: begin
          if (ev_r == EV_SEED) count_r <= count_r + CountW'(1);
          state_r <= S_DONE;
        end
        S_LIST_RD: state_r <= S_SITE;
        S_SITE: begin
          if (frac_r < athr_r) begin
            ev_r <= EV_ANNIH; orow_r <= cr; ocol_r <= cc;
            state_r <= S_LAST_WAIT;
          end else begin
            site_r <= nsite; orow_r <= tr; ocol_r <= tc;
            ev_r <= (frac_r < cthr_r) ? EV_CREATE : EV_COAG;
            state_r <= S_NB_CHK;
          end
        end
        S_NB_CHK: begin
          // settle the event from the neighbour's occupancy
          state_r <= S_DONE;
          if (ev_r == EV_CREATE) begin
            if (!occ_rd && !full) count_r <= count_r + CountW'(1);
            else begin ev_r <= EV_NONE; orow_r <= 7'd0; ocol_r <= 7'd0; end
          end else if (occ_rd) begin
            state_r <= S_MAP_WAIT;
          end else begin
            ev_r <= EV_NONE; orow_r <= 7'd0; ocol_r <= 7'd0;
          end
        end
        S_MAP_WAIT: begin
          slot_r <= map_rd;
          state_r <= S_DROP;
        end
        S_LAST_WAIT: state_r <= S_DROP;
        S_DROP: begin
          count_r <= count_r - CountW'(1);
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_event_res <= ev_r;
          out_changed_row <= orow_r;
          out_changed_col <= ocol_r;
          out_occupied_count <= 13'(count_r);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== dv/tb_lattice_birth_death_update_top.sv =====
// testbench for the lattice birth/death update block: seeds, monte carlo events, reconfiguration
// uses lbdu_pkg and lattice_birth_death_update_top; holds its own lattice predictor and a scoreboard
`timescale 1ns / 1ps
`default_nettype none

module tb_lattice_birth_death_update_top;
  import lbdu_pkg::*;

  typedef struct packed {
    event_t      ev;
    logic [6:0]  row;
    logic [6:0]  col;
    logic [12:0] cnt;
  } lattice_result_t;

  // lattice predictor and queue of expected results
  class lattice_scoreboard;
    bit          occ[SiteCap];
    int unsigned slot_site[SiteCap];
    int unsigned site_slot[SiteCap];
    int unsigned n_occ;
    int unsigned rows_cfg, cols_cfg, athr, cthr;
    lattice_result_t pending[$];
    int unsigned errors;

    function void clear();
      foreach (occ[i]) occ[i] = 0;
      n_occ = 0;
      rows_cfg = 64; cols_cfg = 64; athr = 21845; cthr = 43690;
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [16:0] val);
      case (idx)
        CFG_ROWS: rows_cfg = val[6:0];
        CFG_COLS: cols_cfg = val[6:0];
        CFG_ATHR: athr = val;
        CFG_CTHR: cthr = val;
        default: ;
      endcase
    endfunction

    function void remove_slot(int unsigned slot);
      int unsigned last;
      last = slot_site[n_occ - 1];
      slot_site[slot] = last;
      site_slot[last] = slot;
      n_occ--;
    endfunction

    function void add_site(int unsigned s);
      occ[s] = 1;
      slot_site[n_occ] = s;
      site_slot[s] = n_occ;
      n_occ++;
    endfunction

    // work out the effect of one accepted item
    function void note_item(bit op, int unsigned idx, int unsigned frac, logic [1:0] dir,
                            int unsigned srow, int unsigned scol);
      int unsigned nr, nc, s, r, c, tr, tc, ns;
      lattice_result_t e;
      nr = rows_cfg < 2 ? 2 : (rows_cfg > MaxRows ? MaxRows : rows_cfg);
      nc = cols_cfg < 2 ? 2 : (cols_cfg > MaxCols ? MaxCols : cols_cfg);
      e.ev = EV_NONE; e.row = 0; e.col = 0;
      if (!op) begin
        if (srow < 1 || srow > nr || scol < 1 || scol > nc) begin
          e.ev = EV_INVALID;
        end else begin
          s = (srow - 1) * MaxCols + (scol - 1);
          if (!occ[s] && n_occ < SiteCap) begin
            add_site(s);
            e.ev = EV_SEED; e.row = 7'(srow); e.col = 7'(scol);
          end
        end
      end else if (idx < 1 || idx > n_occ) begin
        e.ev = EV_INVALID;
      end else begin
        s = slot_site[idx - 1];
        r = s / MaxCols + 1;
        c = s % MaxCols + 1;
        if (frac < athr) begin
          occ[s] = 0;
          remove_slot(idx - 1);
          e.ev = EV_ANNIH; e.row = 7'(r); e.col = 7'(c);
        end else begin
          tr = r; tc = c;
          case (dir)
            DIR_UP:   tr = (r <= 1) ? nr : r - 1;
            DIR_DOWN: tr = (r >= nr) ? 1 : r + 1;
            DIR_LEFT: tc = (c <= 1) ? nc : c - 1;
            default:  tc = (c >= nc) ? 1 : c + 1;
          endcase
          ns = (tr - 1) * MaxCols + (tc - 1);
          if (frac < cthr) begin
            if (!occ[ns] && n_occ < SiteCap) begin
              add_site(ns);
              e.ev = EV_CREATE; e.row = 7'(tr); e.col = 7'(tc);
            end
          end else if (occ[ns]) begin
            occ[ns] = 0;
            remove_slot(site_slot[ns]);
            e.ev = EV_COAG; e.row = 7'(tr); e.col = 7'(tc);
          end
        end
      end
      e.cnt = 13'(n_occ);
      pending.push_back(e);
    endfunction

    function void check_result(lattice_result_t got);
      lattice_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result ev=%0d row=%0d col=%0d cnt=%0d", $time,
                 got.ev, got.row, got.col, got.cnt);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.ev !== exp_r.ev) begin
        $display("%0t: event_res expected %0d actual %0d", $time, exp_r.ev, got.ev);
        errors++;
      end
      if (got.row !== exp_r.row) begin
        $display("%0t: changed_row expected %0d actual %0d", $time, exp_r.row, got.row);
        errors++;
      end
      if (got.col !== exp_r.col) begin
        $display("%0t: changed_col expected %0d actual %0d", $time, exp_r.col, got.col);
        errors++;
      end
      if (got.cnt !== exp_r.cnt) begin
        $display("%0t: occupied_count expected %0d actual %0d", $time, exp_r.cnt, got.cnt);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic        in_operation = 0;
  logic [12:0] in_list_index = 0;
  logic [15:0] in_rand_frac = 0;
  logic [1:0]  in_direction = 0;
  logic [6:0]  in_seed_row = 0;
  logic [6:0]  in_seed_col = 0;
  logic        out_valid;
  logic [2:0]  out_event_res;
  logic [6:0]  out_changed_row;
  logic [6:0]  out_changed_col;
  logic [12:0] out_occupied_count;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 0;
  logic [16:0] cfg_data = 0;

  lattice_scoreboard board;
  int unsigned       idle_pct = 37;

  lattice_birth_death_update_top u_top (.*);

  always #1 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_result('{event_t'(out_event_res), out_changed_row, out_changed_col,
                           out_occupied_count});
  end

  // one configuration register write
  task automatic write_cfg(logic [1:0] idx, logic [16:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // one item transfer, with random gaps before it
  task automatic send_item(bit op, logic [12:0] idx, logic [15:0] frac, logic [1:0] dir,
                           logic [6:0] srow, logic [6:0] scol);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1; in_operation <= op; in_list_index <= idx; in_rand_frac <= frac;
    in_direction <= dir; in_seed_row <= srow; in_seed_col <= scol;
    do @(posedge clk); while (busy);
    board.note_item(op, idx, frac, dir, srow, scol);
    @(negedge clk);
    start <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_seed();
    send_item(0, 13'($urandom), 16'($urandom), 2'($urandom),
              7'($urandom_range(board.rows_cfg + 1)), 7'($urandom_range(board.cols_cfg + 1)));
  endtask

  // update aimed mostly at live entries
  task automatic random_update();
    logic [12:0] idx;
    if ($urandom_range(9) == 0) idx = 13'($urandom);
    else idx = 13'($urandom_range(board.n_occ + 1));
    send_item(1, idx, 16'($urandom), 2'($urandom), 7'($urandom), 7'($urandom));
  endtask

  task automatic random_phase(int n, int seed_pct);
    repeat (n) begin
      if ($urandom_range(99) < seed_pct) random_seed();
      else random_update();
    end
    drain();
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: seeds at corners, invalid and occupied cases, every event and direction
    send_item(0, 0, 0, 0, 1, 1);
    send_item(0, 0, 0, 0, 64, 64);
    send_item(0, 0, 0, 0, 1, 1);
    send_item(0, 0, 0, 0, 0, 5);
    send_item(0, 0, 0, 0, 65, 1);
    send_item(0, 0, 0, 0, 127, 127);
    send_item(1, 0, 0, 0, 0, 0);
    send_item(1, 13'h1fff, 0, 0, 0, 0);
    send_item(1, 1, 30000, 0, 0, 0);
    send_item(1, 1, 30000, 1, 0, 0);
    send_item(1, 2, 30000, 2, 0, 0);
    send_item(1, 2, 30000, 3, 0, 0);
    send_item(1, 1, 16'hffff, 1, 0, 0);
    send_item(1, 1, 16'hffff, 0, 0, 0);
    send_item(1, 1, 0, 0, 0, 0);
    send_item(1, 13'(board.n_occ), 0, 0, 0, 0);
    drain();

    // shrunk lattice with entries past the edge, clamped dimensions
    write_cfg(CFG_ROWS, 0);
    write_cfg(CFG_COLS, 17'h7f);
    write_cfg(CFG_ATHR, 0);
    write_cfg(CFG_CTHR, 17'h10000);
    send_item(1, 1, 16'hffff, 1, 0, 0);
    send_item(0, 0, 0, 0, 2, 64);
    send_item(0, 0, 0, 0, 3, 1);
    drain();

    // random phases over several settings
    write_cfg(CFG_ROWS, 64); write_cfg(CFG_COLS, 64);
    write_cfg(CFG_ATHR, 21845); write_cfg(CFG_CTHR, 43690);
    random_phase(300, 40);
    write_cfg(CFG_ROWS, 2); write_cfg(CFG_COLS, 3);
    write_cfg(CFG_ATHR, 10000); write_cfg(CFG_CTHR, 50000);
    random_phase(200, 30);
    idle_pct = 0;
    write_cfg(CFG_ROWS, 8); write_cfg(CFG_COLS, 5);
    write_cfg(CFG_ATHR, 0); write_cfg(CFG_CTHR, 30000);
    random_phase(200, 20);
    idle_pct = 37;
    write_cfg(CFG_ATHR, 17'h10000); write_cfg(CFG_CTHR, 0);
    random_phase(100, 60);
    write_cfg(CFG_ROWS, 13); write_cfg(CFG_COLS, 64);
    write_cfg(CFG_ATHR, 5000); write_cfg(CFG_CTHR, 17'h1ffff);
    random_phase(250, 30);
    write_cfg(CFG_ROWS, 1); write_cfg(CFG_COLS, 100);
    write_cfg(CFG_ATHR, 20000); write_cfg(CFG_CTHR, 40000);
    random_phase(280, 25);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lbdu_pkg.sv
rtl/lbdu_ram.sv
rtl/lattice_birth_death_update_top.sv
dv/tb_lattice_birth_death_update_top.sv
